// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on clk, switched off while reset is applied
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check sampled on clk that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sbcr_pkg.sv -----
// ---------------------------------------------------------------------------
// sbcr_pkg
// Types, constants and helpers for the swept box collision resolver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbcr_pkg;

	// width of the internal compare and snap arithmetic
	localparam int WIDE_W = 36;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t WIDE_POS_MAX = 36'sd2147483647;
	localparam wide_t WIDE_POS_MIN = -36'sd2147483648;

	// time step after reset, Q0.16 seconds
	localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

	// input item
	typedef struct packed {
		logic signed [31:0] a_pos_x;
		logic signed [31:0] a_pos_y;
		logic signed [31:0] a_vel_x;
		logic signed [31:0] a_vel_y;
		logic signed [31:0] b_pos_x;
		logic signed [31:0] b_pos_y;
		logic signed [31:0] b_vel_x;
		logic signed [31:0] b_vel_y;
		logic [31:0]        a_size;
		logic [31:0]        b_size;
		logic [3:0]         pair_flags;
	} in_t;

	// result item
	typedef struct packed {
		logic signed [31:0] new_a_pos_x;
		logic signed [31:0] new_a_pos_y;
		logic signed [31:0] new_a_vel_x;
		logic signed [31:0] new_a_vel_y;
		logic signed [31:0] new_b_pos_x;
		logic signed [31:0] new_b_pos_y;
		logic signed [31:0] new_b_vel_x;
		logic signed [31:0] new_b_vel_y;
		logic               a_grounded;
		logic               b_grounded;
		logic               touched;
	} out_t;

	// working state of one pair as it moves down the pipe
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic [15:0]        aw;
		logic [15:0]        ah;
		logic [15:0]        bw;
		logic [15:0]        bh;
		logic               aimm;
		logic               bimm;
		logic               solid;
		logic               corner;
	} pair_t;

	// contact status collected along the pipe
	typedef struct packed {
		logic ag;
		logic bg;
		logic touch;
	} stat_t;

	// sign-extend a Q24.8 position into the wide domain
	function automatic wide_t wpos(input logic signed [31:0] p);
		return wide_t'(p);
	endfunction

	// whole-pixel size to Q24.8 in the wide domain
	function automatic wide_t wsz(input logic [15:0] s);
		return wide_t'({s, 8'h00});
	endfunction

	// clamp a wide value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		if (v > WIDE_POS_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < WIDE_POS_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/swept_box_collision_resolver.sv -----
// ---------------------------------------------------------------------------
// swept_box_collision_resolver
// Swept AABB contact response for a stream of box pairs, four-stage pipe.
// ---------------------------------------------------------------------------
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    in_data   (sbcr_pkg::in_t)
//  out_*        out  out_valid/out_ready  out_data  (sbcr_pkg::out_t)
//  cfg_*        in   cfg_we               cfg_wdata (time step, Q0.16)
//
//  One pair per cycle sustained while out_ready is high; a pair passes
//  four register stages before out_valid rises. Stage 1 forms the four
//  displacements (multipliers), stage 2 resolves the vertical axis, stage 3
//  recomputes vertical displacements, stage 4 resolves the horizontal axis
//  and holds the result item.
//  A stall only holds stages that are full and blocked; empty stages fill.
//  Reset clears all valid bits and loads the default time step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module swept_box_collision_resolver (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbcr_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sbcr_pkg::out_t   out_data,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata
);

	logic [15:0] time_step_q;

	sbcr_pkg::pair_t pair_in;
	logic signed [31:0] dax_c, day_c, dbx_c, dby_c;
	logic signed [31:0] day2_c, dby2_c;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	sbcr_pkg::pair_t pair_s1, pair_s2, pair_s3;
	logic signed [31:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [31:0] dax_s2, dbx_s2;
	logic signed [31:0] dax_s3, day_s3, dbx_s3, dby_s3;
	sbcr_pkg::stat_t stat_s2, stat_s3;
	sbcr_pkg::out_t out_s4;

	sbcr_pkg::pair_t vert_pair;
	sbcr_pkg::stat_t vert_stat;
	sbcr_pkg::out_t horz_out;

	logic out_both_gnd, out_any_gnd, s2_any_gnd;

	// time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= sbcr_pkg::TIME_STEP_RESET;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	// unpack input item
	always_comb begin
		pair_in.ax     = in_data.a_pos_x;
		pair_in.ay     = in_data.a_pos_y;
		pair_in.avx    = in_data.a_vel_x;
		pair_in.avy    = in_data.a_vel_y;
		pair_in.bx     = in_data.b_pos_x;
		pair_in.by     = in_data.b_pos_y;
		pair_in.bvx    = in_data.b_vel_x;
		pair_in.bvy    = in_data.b_vel_y;
		pair_in.aw     = in_data.a_size[31:16];
		pair_in.ah     = in_data.a_size[15:0];
		pair_in.bw     = in_data.b_size[31:16];
		pair_in.bh     = in_data.b_size[15:0];
		pair_in.aimm   = in_data.pair_flags[0];
		pair_in.bimm   = in_data.pair_flags[1];
		pair_in.solid  = in_data.pair_flags[2];
		pair_in.corner = in_data.pair_flags[3];
	end

	// stage 1 displacements
	sbcr_disp u_disp_ax (.vel(pair_in.avx), .time_step(time_step_q), .disp(dax_c));
	sbcr_disp u_disp_ay (.vel(pair_in.avy), .time_step(time_step_q), .disp(day_c));
	sbcr_disp u_disp_bx (.vel(pair_in.bvx), .time_step(time_step_q), .disp(dbx_c));
	sbcr_disp u_disp_by (.vel(pair_in.bvy), .time_step(time_step_q), .disp(dby_c));

	// stage 2 vertical resolve
	sbcr_vert u_vert (
		.pair_in  (pair_s1),
		.dax      (dax_s1),
		.day      (day_s1),
		.dbx      (dbx_s1),
		.dby      (dby_s1),
		.pair_out (vert_pair),
		.stat     (vert_stat)
	);

	// stage 3 vertical displacements from resolved velocities
	sbcr_disp u_disp_ay2 (.vel(pair_s2.avy), .time_step(time_step_q), .disp(day2_c));
	sbcr_disp u_disp_by2 (.vel(pair_s2.bvy), .time_step(time_step_q), .disp(dby2_c));

	// stage 4 horizontal resolve
	sbcr_horz u_horz (
		.pair_in (pair_s3),
		.stat_in (stat_s3),
		.dax     (dax_s3),
		.day     (day_s3),
		.dbx     (dbx_s3),
		.dby     (dby_s3),
		.result  (horz_out)
	);

	// per-stage ready: a stage moves when empty or when its successor moves
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage payload registers
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			pair_s1 <= pair_in;
			dax_s1  <= dax_c;
			day_s1  <= day_c;
			dbx_s1  <= dbx_c;
			dby_s1  <= dby_c;
		end
		if (ready_s2 && valid_s1) begin
			pair_s2 <= vert_pair;
			stat_s2 <= vert_stat;
			dax_s2  <= dax_s1;
			dbx_s2  <= dbx_s1;
		end
		if (ready_s3 && valid_s2) begin
			pair_s3 <= pair_s2;
			stat_s3 <= stat_s2;
			dax_s3  <= dax_s2;
			dbx_s3  <= dbx_s2;
			day_s3  <= day2_c;
			dby_s3  <= dby2_c;
		end
		if (ready_s4 && valid_s3) begin
			out_s4 <= horz_out;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = out_s4;

	// grounded summaries for the checks
	assign out_both_gnd = out_data.a_grounded && out_data.b_grounded;
	assign out_any_gnd  = out_data.a_grounded || out_data.b_grounded;
	assign s2_any_gnd   = stat_s2.ag || stat_s2.bg;

	// checks
	`ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !out_valid, "output valid out of reset")
	`ASSERT_CLK(a_ground_excl, out_valid |-> !out_both_gnd, "both boxes grounded")
	`ASSERT_CLK(a_ground_touch, out_valid && out_any_gnd |-> out_data.touched, "ground no touch")
	`ASSERT_CLK(a_nonsolid_flat, valid_s2 && !pair_s2.solid |-> !s2_any_gnd, "non-solid grounded")

endmodule

// ----- hdl/sbcr_disp.sv -----
// ---------------------------------------------------------------------------
// sbcr_disp
// Displacement over one time step: floor(vel * time_step / 65536), Q24.8.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_disp (
	input  logic signed [31:0] vel,
	input  logic [15:0]        time_step,
	output logic signed [31:0] disp
);

	logic signed [47:0] prod;

	// 32 x 17 signed product; arithmetic shift gives the floor
	assign prod = vel * $signed({1'b0, time_step});
	assign disp = prod[47:16];

endmodule

// ----- hdl/sbcr_vert.sv -----
// ---------------------------------------------------------------------------
// sbcr_vert
// Vertical resolve: A hit from below or from above, snap and velocity exchange.
// Also carries the plain swept overlap test for non-solid pairs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_vert (
	input  sbcr_pkg::pair_t    pair_in,
	input  logic signed [31:0] dax,
	input  logic signed [31:0] day,
	input  logic signed [31:0] dbx,
	input  logic signed [31:0] dby,
	output sbcr_pkg::pair_t    pair_out,
	output sbcr_pkg::stat_t    stat
);

	sbcr_pkg::wide_t ax, ay, bx, by, aw, ah, bw, bh;
	sbcr_pkg::wide_t wdax, wday, wdbx, wdby, cax, cbx;
	logic xov, hit_bot, hit_top, ns_ov;
	logic signed [31:0] avy_n, bvy_n;
	logic signed [31:0] ay_bot, by_bot, ay_top, by_top;

	// widen operands
	always_comb begin
		ax   = sbcr_pkg::wpos(pair_in.ax);
		ay   = sbcr_pkg::wpos(pair_in.ay);
		bx   = sbcr_pkg::wpos(pair_in.bx);
		by   = sbcr_pkg::wpos(pair_in.by);
		aw   = sbcr_pkg::wsz(pair_in.aw);
		ah   = sbcr_pkg::wsz(pair_in.ah);
		bw   = sbcr_pkg::wsz(pair_in.bw);
		bh   = sbcr_pkg::wsz(pair_in.bh);
		wdax = sbcr_pkg::wpos(dax);
		wday = sbcr_pkg::wpos(day);
		wdbx = sbcr_pkg::wpos(dbx);
		wdby = sbcr_pkg::wpos(dby);
		cax  = pair_in.corner ? wdax : '0;
		cbx  = pair_in.corner ? wdbx : '0;
	end

	// contact tests
	assign xov     = (ax + aw + cax > bx + cbx) && (ax + cax < bx + bw + cbx);
	assign hit_bot = (ay + wday < by + wdby + bh) && (ay >= by + bh) && xov;
	assign hit_top = (ay + ah + wday > by + wdby) && (ay + ah <= by) && xov;
	assign ns_ov   = (ay + wday < by + bh + wdby) && (ay + ah + wday > by + wdby) &&
	                 (ax + wdax < bx + bw + wdbx) && (ax + aw + wdax > bx + wdbx);

	// velocity exchange, B follows the value A just took
	assign avy_n = pair_in.bimm ? pair_in.bvy : '0;
	assign bvy_n = pair_in.aimm ? avy_n : '0;

	// snap candidates, B placed against the snapped A
	always_comb begin
		ay_bot = pair_in.aimm ? pair_in.ay : sbcr_pkg::sat32(by + bh);
		by_bot = pair_in.bimm ? pair_in.by : sbcr_pkg::sat32(sbcr_pkg::wpos(ay_bot) - bh);
		ay_top = pair_in.aimm ? pair_in.ay : sbcr_pkg::sat32(by - ah);
		by_top = pair_in.bimm ? pair_in.by : sbcr_pkg::sat32(sbcr_pkg::wpos(ay_top) + ah);
	end

	// select result
	always_comb begin
		pair_out   = pair_in;
		stat.ag    = 1'b0;
		stat.bg    = 1'b0;
		stat.touch = 1'b0;
		if (!pair_in.solid) begin
			stat.touch = ns_ov;
		end else if (hit_bot) begin
			pair_out.avy = avy_n;
			pair_out.bvy = bvy_n;
			pair_out.ay  = ay_bot;
			pair_out.by  = by_bot;
			stat.bg      = 1'b1;
			stat.touch   = 1'b1;
		end else if (hit_top) begin
			pair_out.avy = avy_n;
			pair_out.bvy = bvy_n;
			pair_out.ay  = ay_top;
			pair_out.by  = by_top;
			stat.ag      = 1'b1;
			stat.touch   = 1'b1;
		end
	end

endmodule

// ----- hdl/sbcr_horz.sv -----
// ---------------------------------------------------------------------------
// sbcr_horz
// Horizontal resolve on the vertically resolved pair; forms the result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_horz (
	input  sbcr_pkg::pair_t    pair_in,
	input  sbcr_pkg::stat_t    stat_in,
	input  logic signed [31:0] dax,
	input  logic signed [31:0] day,
	input  logic signed [31:0] dbx,
	input  logic signed [31:0] dby,
	output sbcr_pkg::out_t     result
);

	sbcr_pkg::wide_t ax, ay, bx, by, aw, ah, bw, bh;
	sbcr_pkg::wide_t wdax, wdbx, cay, cby;
	logic yov, hit_rt, hit_lf;
	logic signed [31:0] avx_n, bvx_n;
	logic signed [31:0] ax_rt, bx_rt, ax_lf, bx_lf;
	sbcr_pkg::pair_t q;

	// widen operands
	always_comb begin
		ax   = sbcr_pkg::wpos(pair_in.ax);
		ay   = sbcr_pkg::wpos(pair_in.ay);
		bx   = sbcr_pkg::wpos(pair_in.bx);
		by   = sbcr_pkg::wpos(pair_in.by);
		aw   = sbcr_pkg::wsz(pair_in.aw);
		ah   = sbcr_pkg::wsz(pair_in.ah);
		bw   = sbcr_pkg::wsz(pair_in.bw);
		bh   = sbcr_pkg::wsz(pair_in.bh);
		wdax = sbcr_pkg::wpos(dax);
		wdbx = sbcr_pkg::wpos(dbx);
		cay  = pair_in.corner ? sbcr_pkg::wpos(day) : '0;
		cby  = pair_in.corner ? sbcr_pkg::wpos(dby) : '0;
	end

	// contact tests
	assign yov    = (ay + ah + cay > by + cby) && (ay + cay < by + bh + cby);
	assign hit_rt = (ax + wdax < bx + wdbx + bw) && (ax >= bx + bw) && yov;
	assign hit_lf = (ax + aw + wdax > bx + wdbx) && (ax + aw <= bx) && yov;

	// velocity exchange
	assign avx_n = pair_in.bimm ? pair_in.bvx : '0;
	assign bvx_n = pair_in.aimm ? avx_n : '0;

	// snap candidates
	always_comb begin
		ax_rt = pair_in.aimm ? pair_in.ax : sbcr_pkg::sat32(bx + bw);
		bx_rt = pair_in.bimm ? pair_in.bx : sbcr_pkg::sat32(sbcr_pkg::wpos(ax_rt) - bw);
		ax_lf = pair_in.aimm ? pair_in.ax : sbcr_pkg::sat32(bx - aw);
		bx_lf = pair_in.bimm ? pair_in.bx : sbcr_pkg::sat32(sbcr_pkg::wpos(ax_lf) + aw);
	end

	// select and pack result
	always_comb begin
		q                  = pair_in;
		result.touched     = stat_in.touch;
		if (pair_in.solid && hit_rt) begin
			q.avx          = avx_n;
			q.bvx          = bvx_n;
			q.ax           = ax_rt;
			q.bx           = bx_rt;
			result.touched = 1'b1;
		end else if (pair_in.solid && hit_lf) begin
			q.avx          = avx_n;
			q.bvx          = bvx_n;
			q.ax           = ax_lf;
			q.bx           = bx_lf;
			result.touched = 1'b1;
		end
		result.new_a_pos_x = q.ax;
		result.new_a_pos_y = q.ay;
		result.new_a_vel_x = q.avx;
		result.new_a_vel_y = q.avy;
		result.new_b_pos_x = q.bx;
		result.new_b_pos_y = q.by;
		result.new_b_vel_x = q.bvx;
		result.new_b_vel_y = q.bvy;
		result.a_grounded  = stat_in.ag;
		result.b_grounded  = stat_in.bg;
	end

endmodule
